FILE: rtl/psieve_pkg.sv
`timescale 1ns / 1ps

package psieve_pkg;

  // Fixed field widths of the request and result ports
  localparam int LimitW   = 9;
  localparam int PrimeW   = 8;
  localparam int OrdinalW = 7;

  // Emission stops after this many primes
  localparam logic [OrdinalW-1:0] MaxResults = 7'd64;

  // Sequencer state codes
  localparam int StateW = 3;
  localparam logic [StateW-1:0] S_IDLE  = 3'd0;
  localparam logic [StateW-1:0] S_CLEAR = 3'd1;
  localparam logic [StateW-1:0] S_BASE  = 3'd2;
  localparam logic [StateW-1:0] S_BCHK  = 3'd3;
  localparam logic [StateW-1:0] S_MARK  = 3'd4;
  localparam logic [StateW-1:0] S_BINC  = 3'd5;
  localparam logic [StateW-1:0] S_SCAN  = 3'd6;

endpackage

FILE: rtl/psieve_marks.sv
`timescale 1ns / 1ps

// Composite-mark bit store: one write port, one registered read port
module psieve_marks #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic          wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic          rdata
);

  logic mem [DEPTH];
  logic rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/psieve_step.sv
`timescale 1ns / 1ps

// Shared step unit: one adder and one less-than compare
module psieve_step #(
  parameter int W = 18
) (
  input  logic [W-1:0] op_a,
  input  logic [W-1:0] op_b,
  input  logic [W-1:0] bound,
  output logic [W-1:0] sum,
  output logic         lt
);

  assign sum = op_a + op_b;
  assign lt  = (op_a < bound);

endmodule

FILE: rtl/prime_sieve_engine_core.sv
`timescale 1ns / 1ps

// Sieve of Eratosthenes. Pulse start while busy is low to hand over a limit L
// (saturated to MAX_LIMIT); busy stays high until the run ends. The block
// emits every prime 2 <= p < L in ascending order, one per out_valid pulse,
// each with its 1-based ordinal; out_last marks the final result, whose
// ordinal is the total count. With no prime below L a single result with
// out_none_found set is emitted. At most 64 primes are emitted. Results are
// single-cycle strobes: the receiver must take each one as it comes and
// cannot stall the block. The final result strobes in the same cycle that
// busy falls. The mark store has one write port and one registered read
// port, and a single shared adder steps the value, base and multiple
// counters.
module prime_sieve_engine_core #(
  parameter int MAX_LIMIT = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [psieve_pkg::LimitW-1:0]  in_limit,
  output logic                           out_valid,
  output logic [psieve_pkg::PrimeW-1:0]  out_prime,
  output logic [psieve_pkg::OrdinalW-1:0] out_ordinal,
  output logic                           out_last,
  output logic                           out_none_found
);

  localparam int LW = $clog2(MAX_LIMIT + 1);
  localparam int AW = $clog2(MAX_LIMIT);
  localparam int W  = 2 * LW;
  localparam logic [psieve_pkg::LimitW-1:0] MaxLimIn = psieve_pkg::LimitW'(MAX_LIMIT);
  localparam logic [LW-1:0] MaxLim = LW'(MAX_LIMIT);

  // Control state
  logic [psieve_pkg::StateW-1:0]   state_r, state_nxt;
  logic                            chk_vld_r, chk_vld_nxt;
  logic                            pend_vld_r, pend_vld_nxt;
  logic [psieve_pkg::OrdinalW-1:0] cnt_r, cnt_nxt;
  logic                            out_valid_r, out_valid_nxt;

  // Datapath registers
  logic [LW-1:0]                   lim_r, lim_nxt;
  logic [LW-1:0]                   v_r, v_nxt;
  logic [LW-1:0]                   b_r, b_nxt;
  logic [LW:0]                     m_r, m_nxt;
  logic [LW-1:0]                   chk_v_r, chk_v_nxt;
  logic [LW-1:0]                   pend_r, pend_nxt;
  logic [psieve_pkg::PrimeW-1:0]   out_prime_r, out_prime_nxt;
  logic [psieve_pkg::OrdinalW-1:0] out_ordinal_r, out_ordinal_nxt;
  logic                            out_last_r, out_last_nxt;
  logic                            out_none_r, out_none_nxt;

  // Step unit and mark store hookup
  logic [W-1:0]  alu_a, alu_b, alu_bound, alu_sum;
  logic          alu_lt;
  logic [W-1:0]  b_ext, b_sq;
  logic          mk_we, mk_wdata, mk_re, mk_rdata;
  logic [AW-1:0] mk_waddr, mk_raddr;

  assign b_ext = W'(b_r);
  assign b_sq  = b_ext * b_ext;

  psieve_step #(.W(W)) u_step (
    .op_a  (alu_a),
    .op_b  (alu_b),
    .bound (alu_bound),
    .sum   (alu_sum),
    .lt    (alu_lt)
  );

  psieve_marks #(.DEPTH(MAX_LIMIT), .AW(AW)) u_marks (
    .clk   (clk),
    .we    (mk_we),
    .waddr (mk_waddr),
    .wdata (mk_wdata),
    .re    (mk_re),
    .raddr (mk_raddr),
    .rdata (mk_rdata)
  );

  // Sequencer: clear, sieve by stepping multiples, then scan and emit
  always_comb begin
    state_nxt       = state_r;
    chk_vld_nxt     = 1'b0;
    pend_vld_nxt    = pend_vld_r;
    cnt_nxt         = cnt_r;
    out_valid_nxt   = 1'b0;
    lim_nxt         = lim_r;
    v_nxt           = v_r;
    b_nxt           = b_r;
    m_nxt           = m_r;
    chk_v_nxt       = chk_v_r;
    pend_nxt        = pend_r;
    out_prime_nxt   = out_prime_r;
    out_ordinal_nxt = out_ordinal_r;
    out_last_nxt    = out_last_r;
    out_none_nxt    = out_none_r;
    alu_a           = W'(v_r);
    alu_b           = W'(1);
    alu_bound       = W'(lim_r);
    mk_we           = 1'b0;
    mk_waddr        = v_r[AW-1:0];
    mk_wdata        = 1'b0;
    mk_re           = 1'b0;
    mk_raddr        = v_r[AW-1:0];

    case (state_r)
      psieve_pkg::S_IDLE: begin
        if (start) begin
          lim_nxt   = (in_limit > MaxLimIn) ? MaxLim : LW'(in_limit);
          v_nxt     = '0;
          state_nxt = psieve_pkg::S_CLEAR;
        end
      end

      // Clear marks below the limit, one entry per cycle
      psieve_pkg::S_CLEAR: begin
        if (alu_lt) begin
          mk_we = 1'b1;
          v_nxt = LW'(alu_sum);
        end else begin
          b_nxt     = LW'(2);
          state_nxt = psieve_pkg::S_BASE;
        end
      end

      // Keep sieving while b*b < limit; fetch the mark of b
      psieve_pkg::S_BASE: begin
        alu_a = b_sq;
        if (alu_lt) begin
          mk_re     = 1'b1;
          mk_raddr  = b_r[AW-1:0];
          state_nxt = psieve_pkg::S_BCHK;
        end else begin
          v_nxt        = LW'(2);
          pend_vld_nxt = 1'b0;
          cnt_nxt      = '0;
          state_nxt    = psieve_pkg::S_SCAN;
        end
      end

      // Skip composite bases, else start marking at b*b
      psieve_pkg::S_BCHK: begin
        alu_a = b_ext;
        if (mk_rdata) begin
          b_nxt     = LW'(alu_sum);
          state_nxt = psieve_pkg::S_BASE;
        end else begin
          m_nxt     = (LW + 1)'(b_sq);
          state_nxt = psieve_pkg::S_MARK;
        end
      end

      // Step through multiples of b
      psieve_pkg::S_MARK: begin
        alu_a = W'(m_r);
        alu_b = b_ext;
        if (alu_lt) begin
          mk_we    = 1'b1;
          mk_waddr = m_r[AW-1:0];
          mk_wdata = 1'b1;
          m_nxt    = (LW + 1)'(alu_sum);
        end else begin
          state_nxt = psieve_pkg::S_BINC;
        end
      end

      psieve_pkg::S_BINC: begin
        alu_a     = b_ext;
        b_nxt     = LW'(alu_sum);
        state_nxt = psieve_pkg::S_BASE;
      end

      // Pipelined scan: read v each cycle, test the previous read.
      // A found prime is held back one find so the last one can be flagged.
      psieve_pkg::S_SCAN: begin
        if (cnt_r == psieve_pkg::MaxResults) begin
          out_valid_nxt   = 1'b1;
          out_prime_nxt   = psieve_pkg::PrimeW'(pend_r);
          out_ordinal_nxt = cnt_r;
          out_last_nxt    = 1'b1;
          out_none_nxt    = 1'b0;
          state_nxt       = psieve_pkg::S_IDLE;
        end else if (!alu_lt && !chk_vld_r) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          if (pend_vld_r) begin
            out_prime_nxt   = psieve_pkg::PrimeW'(pend_r);
            out_ordinal_nxt = cnt_r;
            out_none_nxt    = 1'b0;
          end else begin
            out_prime_nxt   = '0;
            out_ordinal_nxt = '0;
            out_none_nxt    = 1'b1;
          end
          state_nxt = psieve_pkg::S_IDLE;
        end else begin
          if (alu_lt) begin
            mk_re       = 1'b1;
            chk_vld_nxt = 1'b1;
            chk_v_nxt   = v_r;
            v_nxt       = LW'(alu_sum);
          end
          if (chk_vld_r && !mk_rdata) begin
            if (pend_vld_r) begin
              out_valid_nxt   = 1'b1;
              out_prime_nxt   = psieve_pkg::PrimeW'(pend_r);
              out_ordinal_nxt = cnt_r;
              out_last_nxt    = 1'b0;
              out_none_nxt    = 1'b0;
            end
            pend_nxt     = chk_v_r;
            pend_vld_nxt = 1'b1;
            cnt_nxt      = cnt_r + 1'b1;
          end
        end
      end

      default: begin
        state_nxt = psieve_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= psieve_pkg::S_IDLE;
      chk_vld_r   <= 1'b0;
      pend_vld_r  <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      b_r         <= '0;
      m_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      chk_vld_r   <= chk_vld_nxt;
      pend_vld_r  <= pend_vld_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      b_r         <= b_nxt;
      m_r         <= m_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    lim_r         <= lim_nxt;
    v_r           <= v_nxt;
    chk_v_r       <= chk_v_nxt;
    pend_r        <= pend_nxt;
    out_prime_r   <= out_prime_nxt;
    out_ordinal_r <= out_ordinal_nxt;
    out_last_r    <= out_last_nxt;
    out_none_r    <= out_none_nxt;
  end

  assign busy           = (state_r != psieve_pkg::S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_prime      = out_prime_r;
  assign out_ordinal    = out_ordinal_r;
  assign out_last       = out_last_r;
  assign out_none_found = out_none_r;

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int MaxLimit      = 256;
  localparam int DirectedCount = 25;
  localparam int RandomCount   = 335;
  localparam int IdlePct       = 23;
  // requests issued inside this window go out back to back
  localparam int SteadyFrom    = 120;
  localparam int SteadyTo      = 220;
  // sender waits for all results after these many requests
  localparam int DrainA        = 40;
  localparam int DrainB        = 300;
  // a full run gives no strobe at all while marking
  localparam int StallLimit    = 4000;
  localparam int TailCycles    = 20;

  typedef struct packed {
    logic [psieve_pkg::PrimeW-1:0]   prime;
    logic [psieve_pkg::OrdinalW-1:0] ordinal;
    logic                            last;
    logic                            none_found;
  } prime_res_t;

  logic                            clk;
  logic                            rst_n;
  logic                            start;
  logic                            busy;
  logic [psieve_pkg::LimitW-1:0]   in_limit;
  logic                            out_valid;
  logic [psieve_pkg::PrimeW-1:0]   out_prime;
  logic [psieve_pkg::OrdinalW-1:0] out_ordinal;
  logic                            out_last;
  logic                            out_none_found;

  logic [psieve_pkg::LimitW-1:0] limit_q [$];
  prime_res_t                    prime_q [$];
  int                            issued;
  int                            fails;
  int                            stall_cycles;

  // predictor state: composite marks and the last sieve positions
  logic                          sieve_marks [0:MaxLimit-1];
  logic [psieve_pkg::LimitW-1:0] sieve_base;
  logic [psieve_pkg::LimitW-1:0] sieve_mult;

  prime_sieve_engine_core #(
    .MAX_LIMIT(MaxLimit)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_limit(in_limit),
    .out_valid(out_valid),
    .out_prime(out_prime),
    .out_ordinal(out_ordinal),
    .out_last(out_last),
    .out_none_found(out_none_found)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Sieve one limit and queue the primes the block should emit
  function automatic void sieve_primes(input logic [psieve_pkg::LimitW-1:0] lim_in);
    int lim;
    int b;
    int m;
    int v;
    int total;
    int found;
    prime_res_t r;
    lim = int'(lim_in);
    if (lim > MaxLimit) lim = MaxLimit;
    for (v = 0; v < lim; v++) sieve_marks[v] = 1'b0;
    for (b = 2; b * b < lim; b++) begin
      sieve_base = psieve_pkg::LimitW'(b);
      if (!sieve_marks[b]) begin
        for (m = b * b; m < lim; m += b) begin
          sieve_mult = psieve_pkg::LimitW'(m);
          sieve_marks[m] = 1'b1;
        end
      end
    end
    // count first so the final prime can carry the last flag
    total = 0;
    for (v = 2; v < lim; v++) if (!sieve_marks[v]) total++;
    if (total > int'(psieve_pkg::MaxResults)) total = int'(psieve_pkg::MaxResults);
    if (total == 0) begin
      r = '{prime: '0, ordinal: '0, last: 1'b1, none_found: 1'b1};
      prime_q.push_back(r);
    end else begin
      found = 0;
      for (v = 2; v < lim && found < total; v++) begin
        if (!sieve_marks[v]) begin
          found++;
          r.prime      = psieve_pkg::PrimeW'(v);
          r.ordinal    = psieve_pkg::OrdinalW'(found);
          r.last       = (found == total);
          r.none_found = 1'b0;
          prime_q.push_back(r);
        end
      end
    end
  endfunction

  // Request driver: holds start until the request is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      start    <= 1'b0;
      in_limit <= '0;
      issued   = 0;
    end else begin
      logic hold;
      if (start && !busy) begin
        sieve_primes(in_limit);
        issued++;
      end
      if (!start || !busy) begin
        hold = ((issued == DrainA || issued == DrainB) && (prime_q.size() != 0 || busy))
            || ((issued < SteadyFrom || issued >= SteadyTo)
                && $urandom_range(99, 0) < IdlePct);
        if (limit_q.size() != 0 && !hold) begin
          start    <= 1'b1;
          in_limit <= limit_q.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Result monitor: every strobe must match the oldest expected prime
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      prime_res_t e;
      if (prime_q.size() == 0) begin
        $error("unexpected result: prime %0d ordinal %0d", out_prime, out_ordinal);
        fails++;
      end else begin
        e = prime_q.pop_front();
        if (out_prime !== e.prime) begin
          $error("prime: expected %0d, got %0d", e.prime, out_prime);
          fails++;
        end
        if (out_ordinal !== e.ordinal) begin
          $error("ordinal: expected %0d, got %0d", e.ordinal, out_ordinal);
          fails++;
        end
        if (out_last !== e.last) begin
          $error("last: expected %0b, got %0b", e.last, out_last);
          fails++;
        end
        if (out_none_found !== e.none_found) begin
          $error("none_found: expected %0b, got %0b", e.none_found, out_none_found);
          fails++;
        end
      end
    end
  end

  // Watchdog on cycles with neither a request nor a result taken
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [psieve_pkg::LimitW-1:0] directed [DirectedCount];
    int pick;
    directed = '{
      9'd0, 9'd1, 9'd2, 9'd3, 9'd4, 9'd5, 9'd6, 9'd7, 9'd8, 9'd9,
      9'd10, 9'd11, 9'd16, 9'd25, 9'd49, 9'd121, 9'd169, 9'd225, 9'd255,
      9'd256, 9'd257, 9'd300, 9'd511, 9'd128, 9'd64
    };
    rst_n = 1'b0;

    // directed: empty runs, small primes, squares, saturation edges
    foreach (directed[i]) limit_q.push_back(directed[i]);
    // random: mostly in range, some tiny, some above the cap
    for (int i = 0; i < RandomCount; i++) begin
      pick = $urandom_range(99, 0);
      if (pick < 20)
        limit_q.push_back(psieve_pkg::LimitW'($urandom_range(12, 0)));
      else if (pick < 80)
        limit_q.push_back(psieve_pkg::LimitW'($urandom_range(MaxLimit, 13)));
      else
        limit_q.push_back(psieve_pkg::LimitW'($urandom_range(511, MaxLimit + 1)));
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // wait for every request to be taken, then for all results
    while (limit_q.size() != 0 || start) @(posedge clk);
    while (prime_q.size() != 0 || busy) @(posedge clk);
    repeat (TailCycles) @(posedge clk);

    if (fails == 0 && prime_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
